// File: rtl/rrlo_pkg.sv
// shared constants, types and helpers for the record ring log
package rrlo_pkg;

  localparam int unsigned RING_BYTES = 1024;
  localparam int unsigned PTR_W      = $clog2(RING_BYTES);
  localparam int unsigned FILL_W     = $clog2(RING_BYTES + 1);
  localparam int unsigned SUM_W      = FILL_W + 1;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned CMP_W      = LEN_W + 2;
  localparam int unsigned HDR_BYTES  = 20;
  localparam int unsigned HDR_W      = 8 * HDR_BYTES;
  localparam int unsigned CHK_BYTES  = 4;
  localparam int unsigned CNT_W      = $clog2(HDR_BYTES + 1);

  localparam int unsigned KIND_W       = 2;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned RLEN_W       = 10;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned IN_DATA_W    = 152;
  localparam int unsigned OUT_FIELDS_W = RLEN_W + 3 * WORD_W + 8;
  localparam int unsigned OUT_DATA_W   = 120;
  localparam int unsigned OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_IDX_W = CFG_AW - 2;
  localparam int unsigned CFG_DW    = 32;

  localparam logic [KIND_W-1:0] K_WR_START = 2'd0;
  localparam logic [KIND_W-1:0] K_WR_BYTE  = 2'd1;
  localparam logic [KIND_W-1:0] K_RD_START = 2'd2;
  localparam logic [KIND_W-1:0] K_RD_BYTE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CHECK = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BUF_SMALL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_RECORD = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_WORD = 1'd0;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [FILL_W-1:0] fill_t;

  typedef struct packed {
    logic       we;
    ptr_t       waddr;
    logic [7:0] wdata;
    logic       re;
    ptr_t       raddr;
  } ram_req_t;

  // pointer advance modulo the ring size, n never above the ring size
  function automatic ptr_t wrap_add(ptr_t p, fill_t n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(n);
    if (s >= SUM_W'(RING_BYTES)) begin
      s = s - SUM_W'(RING_BYTES);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// File: rtl/record_ring_log_overwrite_top.sv
// top level of the record ring log: register port, sequencer and ring storage
//
// Log records go into a 1024-byte ring as a 20-byte header plus payload.
// Requests arrive on the in_ stream, kind in in_tuser; each gives exactly
// one result on the out_ stream, status in out_tuser, final payload byte
// of a record flagged by out_tlast. The magic word is written through the
// cfg_ register port, by the user only while no request is in flight;
// the block itself does not enforce this.
// Payload byte writes and reads and rejected write starts go straight to
// S_FIN, which registers the result. A read start drops the unread rest
// of the current record, then reads the header byte by byte, unless the
// ring holds no whole header. A write start evicts old records, with two
// ring reads and a drop step per evicted header, then writes one ring
// byte per header byte. The ring has one write and one read port.
// in_tready is low while a request is worked on; a stalled output holds
// its result and a new request can still be taken, but its result waits.
// Reset empties the ring and clears the magic word; ring contents stay as
// they were.
module record_ring_log_overwrite_top
  import rrlo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // length, check_word, pid, sec, nsec, data_in
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // rec_len, rec_pid, rec_sec, rec_nsec, data_out, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [STATUS_W-1:0]   out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  logic [WORD_W-1:0]    magic_word_r, magic_word_nxt;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;
  ram_req_t             ram_req;
  logic [7:0]           ram_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_idx == REG_MAGIC_WORD) ? magic_word_r : '0;

  always_comb begin
    magic_word_nxt = magic_word_r;
    if (cfg_wr && (cfg_idx == REG_MAGIC_WORD)) begin
      magic_word_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_word_r <= '0;
    end else begin
      magic_word_r <= magic_word_nxt;
    end
  end

  rrlo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .magic_word (magic_word_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata)
  );

  rrlo_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in progress");

  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == ST_OK)
    else $error("last flag on a failed result");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata == '0)
    else $error("failed result carries data");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_NO_RECORD)
    else $error("undefined status code");

endmodule

// File: rtl/rrlo_ram.sv
// byte ring storage, one write port and one registered read port
module rrlo_ram
  import rrlo_pkg::*;
(
  input  logic       clk,
  input  ram_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0] mem [RING_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// File: rtl/rrlo_ctrl.sv
// request sequencer: header store, eviction walk, header pop and payload bytes
module rrlo_ctrl
  import rrlo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [WORD_W-1:0]     magic_word,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]   out_tuser,
  output logic                  out_tlast,
  output ram_req_t              ram_req,
  input  logic [7:0]            ram_rdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_EVCHK = 4'd2;
  localparam logic [3:0] S_HL0   = 4'd3;
  localparam logic [3:0] S_HL1   = 4'd4;
  localparam logic [3:0] S_HDRW  = 4'd5;
  localparam logic [3:0] S_RCHK  = 4'd6;
  localparam logic [3:0] S_RHDR  = 4'd7;
  localparam logic [3:0] S_RDEC  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state_r, state_nxt;
  ptr_t       wp_r, wp_nxt;
  ptr_t       head_r, head_nxt;
  fill_t      fill_r, fill_nxt;
  fill_t      wr_rem_r, wr_rem_nxt;
  fill_t      rd_rem_r, rd_rem_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;

  logic [HDR_W-1:0]      hdr_r, hdr_nxt;
  fill_t                 pay_r, pay_nxt;
  fill_t                 need_r, need_nxt;
  logic [LEN_W-1:0]      cap_r, cap_nxt;
  ptr_t                  rp_r, rp_nxt;
  logic [7:0]            lo_r, lo_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  is_wr_r, is_wr_nxt;
  logic [STATUS_W-1:0]   st_r, st_nxt;
  logic                  rec_ok_r, rec_ok_nxt;
  logic                  byte_ok_r, byte_ok_nxt;
  logic                  last_r, last_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [STATUS_W-1:0]   out_tuser_r, out_tuser_nxt;
  logic                  out_tlast_r, out_tlast_nxt;

  logic [LEN_W-1:0]  in_len;
  logic [WORD_W-1:0] in_chk, in_pid, in_sec, in_nsec;
  logic [7:0]        in_byte;
  logic              in_fire;
  logic              too_large, bad_chk, ev_hit, rd_small;
  fill_t             in_pay, in_need, close_n, f2;
  logic [LEN_W-1:0]  ev_len, rd_len;
  logic [RLEN_W-1:0] o_len;
  logic [WORD_W-1:0] o_pid, o_sec, o_nsec;
  logic [7:0]        o_byte;

  assign in_len  = in_tdata[15:0];
  assign in_chk  = in_tdata[47:16];
  assign in_pid  = in_tdata[79:48];
  assign in_sec  = in_tdata[111:80];
  assign in_nsec = in_tdata[143:112];
  assign in_byte = in_tdata[151:144];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  assign too_large = (CMP_W'(in_len) + CMP_W'(HDR_BYTES)) > CMP_W'(RING_BYTES);
  assign bad_chk   = (in_len < LEN_W'(CHK_BYTES)) || (in_chk != magic_word);
  assign in_pay    = FILL_W'(in_len - LEN_W'(CHK_BYTES));
  assign in_need   = FILL_W'(CMP_W'(in_len) + CMP_W'(HDR_BYTES));
  assign close_n   = (rd_rem_r < fill_r) ? rd_rem_r : fill_r;
  assign ev_hit    = (fill_r != '0) &&
                     ((SUM_W'(need_r) + SUM_W'(fill_r)) >= SUM_W'(RING_BYTES));
  assign f2        = fill_r - FILL_W'(HDR_BYTES);
  assign ev_len    = {ram_rdata, lo_r};
  assign rd_len    = hdr_r[15:0];
  assign rd_small  = CMP_W'(cap_r) < (CMP_W'(rd_len) + CMP_W'(HDR_BYTES));

  assign o_len  = rec_ok_r  ? hdr_r[RLEN_W-1:0] : '0;
  assign o_pid  = rec_ok_r  ? hdr_r[63:32]      : '0;
  assign o_sec  = rec_ok_r  ? hdr_r[127:96]     : '0;
  assign o_nsec = rec_ok_r  ? hdr_r[159:128]    : '0;
  assign o_byte = byte_ok_r ? ram_rdata         : '0;

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    wr_rem_nxt     = wr_rem_r;
    rd_rem_nxt     = rd_rem_r;
    hdr_nxt        = hdr_r;
    pay_nxt        = pay_r;
    need_nxt       = need_r;
    cap_nxt        = cap_r;
    rp_nxt         = rp_r;
    lo_nxt         = lo_r;
    cnt_nxt        = cnt_r;
    is_wr_nxt      = is_wr_r;
    st_nxt         = st_r;
    rec_ok_nxt     = rec_ok_r;
    byte_ok_nxt    = byte_ok_r;
    last_nxt       = last_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;

    ram_req.we    = 1'b0;
    ram_req.waddr = wp_r;
    ram_req.wdata = in_byte;
    ram_req.re    = 1'b0;
    ram_req.raddr = head_r;

    unique case (state_r)
      S_IDLE: begin
        ram_req.re = 1'b1;
        if (in_fire) begin
          st_nxt      = ST_OK;
          rec_ok_nxt  = 1'b0;
          byte_ok_nxt = 1'b0;
          last_nxt    = 1'b0;
          unique case (in_tuser)
            K_WR_START: begin
              if (too_large) begin
                st_nxt    = ST_TOO_LARGE;
                state_nxt = S_FIN;
              end else if (bad_chk) begin
                st_nxt    = ST_BAD_CHECK;
                state_nxt = S_FIN;
              end else begin
                hdr_nxt    = {in_nsec, in_sec, {WORD_W{1'b0}}, in_pid,
                              LEN_W'(HDR_BYTES), LEN_W'(in_pay)};
                pay_nxt    = in_pay;
                need_nxt   = in_need;
                wp_nxt     = wrap_add(wp_r, wr_rem_r);
                wr_rem_nxt = '0;
                is_wr_nxt  = 1'b1;
                state_nxt  = S_PREP;
              end
            end
            K_WR_BYTE: begin
              if (wr_rem_r == '0) begin
                st_nxt = ST_NO_RECORD;
              end else begin
                ram_req.we = 1'b1;
                wp_nxt     = wrap_add(wp_r, FILL_W'(1));
                wr_rem_nxt = wr_rem_r - FILL_W'(1);
              end
              state_nxt = S_FIN;
            end
            K_RD_START: begin
              cap_nxt   = in_len;
              is_wr_nxt = 1'b0;
              state_nxt = S_PREP;
            end
            K_RD_BYTE: begin
              if ((rd_rem_r == '0) || (fill_r == '0)) begin
                st_nxt     = ST_NO_RECORD;
                rd_rem_nxt = '0;
              end else begin
                byte_ok_nxt = 1'b1;
                head_nxt    = wrap_add(head_r, FILL_W'(1));
                fill_nxt    = fill_r - FILL_W'(1);
                rd_rem_nxt  = rd_rem_r - FILL_W'(1);
                last_nxt    = (rd_rem_r == FILL_W'(1));
              end
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_PREP: begin
        // discard the unread rest of the record being read
        head_nxt   = wrap_add(head_r, close_n);
        fill_nxt   = fill_r - close_n;
        rd_rem_nxt = '0;
        state_nxt  = is_wr_r ? S_EVCHK : S_RCHK;
      end
      S_EVCHK: begin
        if (!ev_hit) begin
          cnt_nxt   = '0;
          state_nxt = S_HDRW;
        end else if (fill_r < FILL_W'(HDR_BYTES)) begin
          head_nxt  = wp_r;
          fill_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_HDRW;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = head_r;
          rp_nxt        = wrap_add(head_r, FILL_W'(1));
          state_nxt     = S_HL0;
        end
      end
      S_HL0: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = rp_r;
        lo_nxt        = ram_rdata;
        state_nxt     = S_HL1;
      end
      S_HL1: begin
        // drop oldest record, or empty the ring on a damaged length
        if (CMP_W'(ev_len) > CMP_W'(f2)) begin
          head_nxt = wp_r;
          fill_nxt = '0;
        end else begin
          head_nxt = wrap_add(head_r, FILL_W'(HDR_BYTES) + FILL_W'(ev_len));
          fill_nxt = f2 - FILL_W'(ev_len);
        end
        state_nxt = S_EVCHK;
      end
      S_HDRW: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = wp_r;
        ram_req.wdata = hdr_r[7:0];
        hdr_nxt       = {8'h00, hdr_r[HDR_W-1:8]};
        wp_nxt        = wrap_add(wp_r, FILL_W'(1));
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(HDR_BYTES - 1)) begin
          fill_nxt   = fill_r + FILL_W'(HDR_BYTES) + pay_r;
          wr_rem_nxt = pay_r;
          st_nxt     = ST_OK;
          state_nxt  = S_FIN;
        end
      end
      S_RCHK: begin
        if (fill_r < FILL_W'(HDR_BYTES)) begin
          if (fill_r != '0) begin
            head_nxt = wp_r;
            fill_nxt = '0;
          end
          st_nxt    = ST_EMPTY;
          state_nxt = S_FIN;
        end else begin
          rp_nxt    = head_r;
          cnt_nxt   = '0;
          state_nxt = S_RHDR;
        end
      end
      S_RHDR: begin
        ram_req.re    = (cnt_r < CNT_W'(HDR_BYTES));
        ram_req.raddr = rp_r;
        rp_nxt        = wrap_add(rp_r, FILL_W'(1));
        cnt_nxt       = cnt_r + CNT_W'(1);
        if (cnt_r != '0) begin
          hdr_nxt = {ram_rdata, hdr_r[HDR_W-1:8]};
        end
        if (cnt_r == CNT_W'(HDR_BYTES)) begin
          state_nxt = S_RDEC;
        end
      end
      S_RDEC: begin
        if (rd_small) begin
          st_nxt = ST_BUF_SMALL;
        end else begin
          rec_ok_nxt = 1'b1;
          if (CMP_W'(rd_len) > CMP_W'(f2)) begin
            head_nxt   = wp_r;
            fill_nxt   = '0;
            rd_rem_nxt = '0;
          end else begin
            head_nxt   = wrap_add(head_r, FILL_W'(HDR_BYTES));
            fill_nxt   = f2;
            rd_rem_nxt = FILL_W'(rd_len);
          end
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{OUT_PAD_W{1'b0}}, o_byte, o_nsec, o_sec, o_pid, o_len};
          out_tuser_nxt  = st_r;
          out_tlast_nxt  = last_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wp_r         <= '0;
      head_r       <= '0;
      fill_r       <= '0;
      wr_rem_r     <= '0;
      rd_rem_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      head_r       <= head_nxt;
      fill_r       <= fill_nxt;
      wr_rem_r     <= wr_rem_nxt;
      rd_rem_r     <= rd_rem_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r       <= hdr_nxt;
    pay_r       <= pay_nxt;
    need_r      <= need_nxt;
    cap_r       <= cap_nxt;
    rp_r        <= rp_nxt;
    lo_r        <= lo_nxt;
    cnt_r       <= cnt_nxt;
    is_wr_r     <= is_wr_nxt;
    st_r        <= st_nxt;
    rec_ok_r    <= rec_ok_nxt;
    byte_ok_r   <= byte_ok_nxt;
    last_r      <= last_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

endmodule
